// ===== design/assert_macros.svh =====
// Assertion macros shared by the vertex transform RTL.
// Each macro expects i_clk and i_rst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VRP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vrp_pkg.sv =====
// Shared types, constants and rounding helper for the vertex transform.
// No dependencies; used by vrp_recip and vertex_rotate_project_core.
package vrp_pkg;

    localparam int unsigned COORD_W    = 16;
    localparam int unsigned COEF_W     = 16;
    localparam int unsigned OUT_W      = 18;
    localparam int unsigned ACC_W      = 36;
    localparam int unsigned INV_W      = 32;
    localparam int unsigned QUO_W      = 29;
    localparam int unsigned MAG_W      = 18;
    localparam int unsigned FRAC_SHIFT = 14;

    localparam logic signed [COEF_W-1:0] COEF_ONE   = 16'sd16384;
    localparam logic signed [OUT_W:0]    DEPTH_BIAS = 19'sd4096;
    localparam logic signed [OUT_W:0]    LIM_MAX19  = 19'sd131071;
    localparam logic signed [OUT_W:0]    LIM_MIN19  = -19'sd131072;
    localparam logic [QUO_W-1:0]         RECIP_NUM  = 29'h1000_0000;
    localparam logic [INV_W-1:0]         INV_SAT    = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        REG_SIN_PITCH = 2'd0,
        REG_COS_PITCH = 2'd1,
        REG_SIN_YAW   = 2'd2,
        REG_COS_YAW   = 2'd3
    } t_cfg_reg;

    // Sideband that rides along the reciprocal pipeline.
    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] depth;
        logic                    neg;
        logic                    zero;
    } t_side;

    // Q.26 sum -> Q.12: round half up, then saturate to 18 bits.
    function automatic logic signed [OUT_W-1:0] f_round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] sh;
        logic signed [OUT_W-1:0] res;
        sh = (acc + 36'sd8192) >>> FRAC_SHIFT;
        if (sh > 36'sd131071) begin
            res = 18'sd131071;
        end else if (sh < -36'sd131072) begin
            res = -18'sd131072;
        end else begin
            res = signed'(sh[OUT_W-1:0]);
        end
        return res;
    endfunction

endpackage

// ===== design/vrp_recip.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on vrp_pkg for widths and the sideband struct.
module vrp_recip (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [vrp_pkg::QUO_W-1:0]   i_num,
    input  logic [vrp_pkg::MAG_W-1:0]   i_mag,
    input  vrp_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [vrp_pkg::QUO_W-1:0]   o_quo,
    output vrp_pkg::t_side              o_side
);

    localparam int unsigned STAGES = vrp_pkg::QUO_W;

    logic [STAGES-1:0]                r_v;
    logic [vrp_pkg::MAG_W-1:0]        r_rem  [STAGES];
    logic [vrp_pkg::MAG_W-1:0]        n_rem  [STAGES];
    logic [vrp_pkg::MAG_W-1:0]        r_mag  [STAGES];
    logic [vrp_pkg::MAG_W-1:0]        n_mag  [STAGES];
    logic [vrp_pkg::QUO_W-1:0]        r_num  [STAGES];
    logic [vrp_pkg::QUO_W-1:0]        n_num  [STAGES];
    logic [vrp_pkg::QUO_W-1:0]        r_quo  [STAGES];
    logic [vrp_pkg::QUO_W-1:0]        n_quo  [STAGES];
    vrp_pkg::t_side                   r_side [STAGES];
    vrp_pkg::t_side                   n_side [STAGES];

    always_comb begin
        logic [vrp_pkg::MAG_W-1:0] p_rem;
        logic [vrp_pkg::MAG_W-1:0] p_mag;
        logic [vrp_pkg::QUO_W-1:0] p_num;
        logic [vrp_pkg::QUO_W-1:0] p_quo;
        logic [vrp_pkg::MAG_W:0]   trial;
        logic                      qbit;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                p_rem     = '0;
                p_mag     = i_mag;
                p_num     = i_num;
                p_quo     = '0;
                n_side[k] = i_side;
            end else begin
                p_rem     = r_rem[k-1];
                p_mag     = r_mag[k-1];
                p_num     = r_num[k-1];
                p_quo     = r_quo[k-1];
                n_side[k] = r_side[k-1];
            end
            // bring down the next numerator bit and try the subtract
            trial = {p_rem, p_num[vrp_pkg::QUO_W-1]};
            qbit  = (trial >= {1'b0, p_mag});
            if (qbit) begin
                n_rem[k] = vrp_pkg::MAG_W'(trial - {1'b0, p_mag});
            end else begin
                n_rem[k] = trial[vrp_pkg::MAG_W-1:0];
            end
            n_mag[k] = p_mag;
            n_num[k] = {p_num[vrp_pkg::QUO_W-2:0], 1'b0};
            n_quo[k] = {p_quo[vrp_pkg::QUO_W-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_mag  <= n_mag;
            r_num  <= n_num;
            r_quo  <= n_quo;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_quo   = r_quo[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

// ===== design/vertex_rotate_project_core.sv =====
// Vertex rotate and project: an accepted request passes through six arithmetic stages,
// 29 divider stages (one quotient bit each) and the output register on its way to the result.
// Throughput one vertex per cycle; a stalled result freezes the whole pipeline in place.
// Reset (synchronous, active low) empties the pipeline and loads identity coefficients
// (sines 0, cosines 1.0). Depends on vrp_pkg, vrp_recip and assert_macros.svh.
`include "assert_macros.svh"

module vertex_rotate_project_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [vrp_pkg::COEF_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [vrp_pkg::COORD_W-1:0]  i_x_in,
    input  logic signed [vrp_pkg::COORD_W-1:0]  i_y_in,
    input  logic signed [vrp_pkg::COORD_W-1:0]  i_z_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [vrp_pkg::OUT_W-1:0]    o_x_out,
    output logic signed [vrp_pkg::OUT_W-1:0]    o_y_out,
    output logic signed [vrp_pkg::OUT_W-1:0]    o_depth_out,
    output logic signed [vrp_pkg::INV_W-1:0]    o_inv_depth,
    output logic                                o_depth_zero
);

    localparam int unsigned OW = vrp_pkg::OUT_W;

    logic signed [vrp_pkg::COEF_W-1:0] r_sin_pitch, r_cos_pitch, r_sin_yaw, r_cos_yaw;

    logic en;
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v, r_out_valid;

    // stage A: first rotation products
    logic signed [31:0]          r_a_xc, r_a_zs, r_a_xs, r_a_zc;
    logic signed [15:0]          r_a_y;
    // stage B: x1, z1
    logic signed [OW-1:0]        r_b_x1, r_b_z1;
    logic signed [15:0]          r_b_y;
    // stage C: second rotation products
    logic signed [31:0]          r_c_yc, r_c_ys;
    logic signed [33:0]          r_c_zs, r_c_zc;
    logic signed [OW-1:0]        r_c_x1;
    // stage D: y2, z2
    logic signed [OW-1:0]        r_d_x1, r_d_y2, r_d_z2;
    // stage E: depth
    logic signed [OW-1:0]        r_e_x1, r_e_y2, r_e_depth;
    logic signed [OW:0]          w_dsum;
    logic signed [OW-1:0]        w_depth;
    // stage F: divider operands
    logic [vrp_pkg::QUO_W-1:0]   r_f_num;
    logic [vrp_pkg::MAG_W-1:0]   r_f_mag;
    vrp_pkg::t_side              r_f_side;
    logic [OW:0]                 w_abs;
    logic [vrp_pkg::MAG_W-1:0]   w_mag;

    logic                        div_valid;
    logic [vrp_pkg::QUO_W-1:0]   div_quo;
    vrp_pkg::t_side              div_side;
    logic [vrp_pkg::INV_W-1:0]   w_quo_ext;

    logic signed [OW-1:0]        r_x_out, r_y_out, r_depth_out;
    logic [vrp_pkg::INV_W-1:0]   r_inv_depth;
    logic                        r_depth_zero;

    // advance everything unless a finished result is held
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_pitch <= '0;
            r_cos_pitch <= vrp_pkg::COEF_ONE;
            r_sin_yaw   <= '0;
            r_cos_yaw   <= vrp_pkg::COEF_ONE;
        end else if (i_cfg_we) begin
            case (vrp_pkg::t_cfg_reg'(i_cfg_idx))
                vrp_pkg::REG_SIN_PITCH: r_sin_pitch <= signed'(i_cfg_data);
                vrp_pkg::REG_COS_PITCH: r_cos_pitch <= signed'(i_cfg_data);
                vrp_pkg::REG_SIN_YAW:   r_sin_yaw   <= signed'(i_cfg_data);
                vrp_pkg::REG_COS_YAW:   r_cos_yaw   <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_d_v       <= 1'b0;
            r_e_v       <= 1'b0;
            r_f_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_v       <= i_in_valid;
            r_b_v       <= r_a_v;
            r_c_v       <= r_b_v;
            r_d_v       <= r_c_v;
            r_e_v       <= r_d_v;
            r_f_v       <= r_e_v;
            r_out_valid <= div_valid;
        end
    end

    always_comb begin
        w_dsum = (OW+1)'(r_d_z2) + vrp_pkg::DEPTH_BIAS;
        if (w_dsum > vrp_pkg::LIM_MAX19) begin
            w_depth = signed'(vrp_pkg::LIM_MAX19[OW-1:0]);
        end else if (w_dsum < vrp_pkg::LIM_MIN19) begin
            w_depth = signed'(vrp_pkg::LIM_MIN19[OW-1:0]);
        end else begin
            w_depth = signed'(w_dsum[OW-1:0]);
        end
        // magnitude of -131072 still fits 18 unsigned bits
        w_abs = r_e_depth[OW-1] ? (OW+1)'(-(OW+1)'(r_e_depth)) : (OW+1)'(r_e_depth);
        w_mag = w_abs[vrp_pkg::MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_xc <= 32'(i_x_in) * 32'(r_cos_pitch);
            r_a_zs <= 32'(i_z_in) * 32'(r_sin_pitch);
            r_a_xs <= 32'(i_x_in) * 32'(r_sin_pitch);
            r_a_zc <= 32'(i_z_in) * 32'(r_cos_pitch);
            r_a_y  <= i_y_in;

            r_b_x1 <= vrp_pkg::f_round_sat(36'(r_a_xc) - 36'(r_a_zs));
            r_b_z1 <= vrp_pkg::f_round_sat(36'(r_a_xs) + 36'(r_a_zc));
            r_b_y  <= r_a_y;

            r_c_yc <= 32'(r_b_y) * 32'(r_cos_yaw);
            r_c_ys <= 32'(r_b_y) * 32'(r_sin_yaw);
            r_c_zs <= 34'(r_b_z1) * 34'(r_sin_yaw);
            r_c_zc <= 34'(r_b_z1) * 34'(r_cos_yaw);
            r_c_x1 <= r_b_x1;

            r_d_y2 <= vrp_pkg::f_round_sat(36'(r_c_yc) - 36'(r_c_zs));
            r_d_z2 <= vrp_pkg::f_round_sat(36'(r_c_ys) + 36'(r_c_zc));
            r_d_x1 <= r_c_x1;

            r_e_depth <= w_depth;
            r_e_x1    <= r_d_x1;
            r_e_y2    <= r_d_y2;

            r_f_mag        <= w_mag;
            r_f_num        <= vrp_pkg::RECIP_NUM + vrp_pkg::QUO_W'(w_mag >> 1);
            r_f_side.x     <= r_e_x1;
            r_f_side.y     <= r_e_y2;
            r_f_side.depth <= r_e_depth;
            r_f_side.neg   <= r_e_depth[OW-1];
            r_f_side.zero  <= (r_e_depth == '0);
        end
    end

    vrp_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_v),
        .i_num   (r_f_num),
        .i_mag   (r_f_mag),
        .i_side  (r_f_side),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    assign w_quo_ext = vrp_pkg::INV_W'(div_quo);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x_out      <= div_side.x;
            r_y_out      <= div_side.y;
            r_depth_out  <= div_side.depth;
            r_depth_zero <= div_side.zero;
            // zero depth saturates; otherwise restore the sign of depth
            if (div_side.zero) begin
                r_inv_depth <= vrp_pkg::INV_SAT;
            end else if (div_side.neg) begin
                r_inv_depth <= -w_quo_ext;
            end else begin
                r_inv_depth <= w_quo_ext;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_x_out      = r_x_out;
    assign o_y_out      = r_y_out;
    assign o_depth_out  = r_depth_out;
    assign o_inv_depth  = signed'(r_inv_depth);
    assign o_depth_zero = r_depth_zero;

    `VRP_ASSERT_IMPLY(a_zero_sat, o_out_valid && o_depth_zero,
        o_inv_depth == vrp_pkg::INV_SAT && o_depth_out == '0,
        "zero depth without saturated reciprocal")
    `VRP_ASSERT_IMPLY(a_inv_sign, o_out_valid && !o_depth_zero,
        o_depth_out != '0 && o_inv_depth != '0 && o_inv_depth[31] == o_depth_out[17],
        "reciprocal sign or zero flag mismatch")
    `VRP_ASSERT_IMPLY(a_stall_cause, o_in_stall, o_out_valid && i_out_stall,
        "input stalled without a held result")
    `VRP_ASSERT_NEXT(a_hold_result, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_inv_depth) && $stable(o_depth_out),
        "held result changed under stall")

endmodule

// ===== bench/vertex_rotate_project_core_test.sv =====
// Self-checking bench for vertex_rotate_project_core: two-plane rotation, depth offset
// and reciprocal, checked against an in-bench predictor under several coefficient sets.
// Depends on vrp_pkg and the core RTL only.
module vertex_rotate_project_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 200;
    localparam int PHASE_COUNT  = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic signed [vrp_pkg::OUT_W-1:0] x;
        logic signed [vrp_pkg::OUT_W-1:0] y;
        logic signed [vrp_pkg::OUT_W-1:0] depth;
        logic signed [vrp_pkg::INV_W-1:0] inv;
        logic                             zero;
    } t_vertex_result;

    class projection_ledger;
        logic signed [vrp_pkg::COEF_W-1:0] coef [4];
        t_vertex_result                    awaited [$];
        int                                mismatches;

        function new();
            coef[vrp_pkg::REG_SIN_PITCH] = '0;
            coef[vrp_pkg::REG_COS_PITCH] = vrp_pkg::COEF_ONE;
            coef[vrp_pkg::REG_SIN_YAW]   = '0;
            coef[vrp_pkg::REG_COS_YAW]   = vrp_pkg::COEF_ONE;
            mismatches                   = 0;
        endfunction

        function void set_coef(vrp_pkg::t_cfg_reg idx, logic [vrp_pkg::COEF_W-1:0] val);
            coef[idx] = signed'(val);
        endfunction

        // Q.26 sum to Q.12: round half up, clamp to 18 bits.
        function longint to_q12(longint acc);
            longint sh;
            sh = (acc + 64'sd8192) >>> vrp_pkg::FRAC_SHIFT;
            if (sh > 64'sd131071) sh = 64'sd131071;
            if (sh < -64'sd131072) sh = -64'sd131072;
            return sh;
        endfunction

        function t_vertex_result rotate_and_project(logic [vrp_pkg::COORD_W-1:0] xr, yr, zr);
            longint         x, y, z, sp, cp, sy, cy;
            longint         x1, z1, y2, z2, depth, mag, q;
            t_vertex_result r;
            x  = longint'(signed'(xr));
            y  = longint'(signed'(yr));
            z  = longint'(signed'(zr));
            sp = longint'(coef[vrp_pkg::REG_SIN_PITCH]);
            cp = longint'(coef[vrp_pkg::REG_COS_PITCH]);
            sy = longint'(coef[vrp_pkg::REG_SIN_YAW]);
            cy = longint'(coef[vrp_pkg::REG_COS_YAW]);
            x1 = to_q12(x * cp - z * sp);
            z1 = to_q12(x * sp + z * cp);
            y2 = to_q12(y * cy - z1 * sy);
            z2 = to_q12(y * sy + z1 * cy);
            depth = z2 + 64'sd4096;
            if (depth > 64'sd131071) depth = 64'sd131071;
            r.x     = x1[vrp_pkg::OUT_W-1:0];
            r.y     = y2[vrp_pkg::OUT_W-1:0];
            r.depth = depth[vrp_pkg::OUT_W-1:0];
            if (depth == 0) begin
                r.inv  = vrp_pkg::INV_SAT;
                r.zero = 1'b1;
            end else begin
                mag = (depth < 0) ? -depth : depth;
                q   = (64'sd268435456 + mag / 2) / mag;
                if (depth < 0) q = -q;
                r.inv  = q[vrp_pkg::INV_W-1:0];
                r.zero = 1'b0;
            end
            return r;
        endfunction

        function void note_request(logic [vrp_pkg::COORD_W-1:0] x, y, z);
            awaited.push_back(rotate_and_project(x, y, z));
        endfunction

        function void check_result(t_vertex_result got);
            t_vertex_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result x=%0d y=%0d depth=%0d inv=%0d zero=%0b",
                             got.x, got.y, got.depth, got.inv, got.zero);
                return;
            end
            want = awaited.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.depth !== want.depth ||
                got.inv !== want.inv || got.zero !== want.zero) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch at %0t: exp x=%0d y=%0d depth=%0d inv=%0d zero=%0b",
                             $realtime, want.x, want.y, want.depth, want.inv, want.zero);
                    $display("    got x=%0d y=%0d depth=%0d inv=%0d zero=%0b",
                             got.x, got.y, got.depth, got.inv, got.zero);
                end
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_cfg_we    = 1'b0;
    logic [1:0]                          i_cfg_idx   = '0;
    logic [vrp_pkg::COEF_W-1:0]          i_cfg_data  = '0;
    logic                                i_in_valid  = 1'b0;
    logic                                o_in_stall;
    logic signed [vrp_pkg::COORD_W-1:0]  i_x_in      = '0;
    logic signed [vrp_pkg::COORD_W-1:0]  i_y_in      = '0;
    logic signed [vrp_pkg::COORD_W-1:0]  i_z_in      = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic signed [vrp_pkg::OUT_W-1:0]    o_x_out;
    logic signed [vrp_pkg::OUT_W-1:0]    o_y_out;
    logic signed [vrp_pkg::OUT_W-1:0]    o_depth_out;
    logic signed [vrp_pkg::INV_W-1:0]    o_inv_depth;
    logic                                o_depth_zero;

    logic in_idle_on    = 1'b1;
    logic out_idle_on   = 1'b1;
    logic pressure_req  = 1'b0;
    logic pressure_done = 1'b0;
    int   hold_left     = 0;
    int   cycle_count   = 0;

    projection_ledger book = new();

    vertex_rotate_project_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_x_in       (i_x_in),
        .i_y_in       (i_y_in),
        .i_z_in       (i_z_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_x_out      (o_x_out),
        .o_y_out      (o_y_out),
        .o_depth_out  (o_depth_out),
        .o_inv_depth  (o_inv_depth),
        .o_depth_zero (o_depth_zero)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the pipe backs up.
    always @(posedge i_clk) begin
        if (pressure_req && !pressure_done) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= out_idle_on && ($urandom_range(99) < 22);
        end
    end

    always @(posedge i_clk) begin
        t_vertex_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.x     = o_x_out;
            got.y     = o_y_out;
            got.depth = o_depth_out;
            got.inv   = o_inv_depth;
            got.zero  = o_depth_zero;
            book.check_result(got);
        end
    end

    function automatic logic [vrp_pkg::COORD_W-1:0] gen_coord(int extreme_pct);
        logic [vrp_pkg::COORD_W-1:0] corners [4];
        corners = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        if ($urandom_range(99) < extreme_pct)
            return corners[$urandom_range(3)];
        return vrp_pkg::COORD_W'($urandom_range(16'hffff));
    endfunction

    // Bias z toward -1.0 so identity-like settings hit zero depth and its neighbors.
    function automatic logic [vrp_pkg::COORD_W-1:0] gen_depth_coord(int extreme_pct);
        if ($urandom_range(99) < 10)
            return vrp_pkg::COORD_W'(-4096 + int'($urandom_range(4)) - 2);
        return gen_coord(extreme_pct);
    endfunction

    function automatic logic [vrp_pkg::COEF_W-1:0] gen_coef();
        if ($urandom_range(99) < 20)
            return vrp_pkg::COEF_W'($urandom_range(16'hffff));
        return vrp_pkg::COEF_W'(int'($urandom_range(32768)) - 16384);
    endfunction

    task automatic load_angles(input logic [vrp_pkg::COEF_W-1:0] sp, cp, sy, cy);
        logic [vrp_pkg::COEF_W-1:0] vals [4];
        vrp_pkg::t_cfg_reg          order [4];
        vals  = '{sp, cp, sy, cy};
        order = '{vrp_pkg::REG_SIN_PITCH, vrp_pkg::REG_COS_PITCH,
                  vrp_pkg::REG_SIN_YAW, vrp_pkg::REG_COS_YAW};
        foreach (vals[k]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= order[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            book.set_coef(order[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offer one request; valid stays up into the next call unless a gap is taken.
    task automatic send_vertex(input logic [vrp_pkg::COORD_W-1:0] x, y, z);
        if (in_idle_on) begin
            while ($urandom_range(99) < 22) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_x_in     <= x;
        i_y_in     <= y;
        i_z_in     <= z;
        do @(posedge i_clk); while (o_in_stall);
        book.note_request(x, y, z);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        logic [vrp_pkg::COORD_W-1:0] dx [12] = '{16'h0000, 16'h7fff, 16'h8000, 16'h7fff,
                                                 16'h0000, 16'h0001, 16'h0000, 16'hffff,
                                                 16'h3039, 16'h8000, 16'h5555, 16'haaaa};
        logic [vrp_pkg::COORD_W-1:0] dy [12] = '{16'h0000, 16'h7fff, 16'h8000, 16'h8000,
                                                 16'h0000, 16'hffff, 16'h0000, 16'h0001,
                                                 16'hcfc7, 16'h7fff, 16'haaaa, 16'h5555};
        logic [vrp_pkg::COORD_W-1:0] dz [12] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0000,
                                                 16'hf000, 16'hf001, 16'hefff, 16'h0001,
                                                 16'h7fff, 16'hf000, 16'h5555, 16'haaaa};
        foreach (dx[k]) send_vertex(dx[k], dy[k], dz[k]);
    endtask

    initial begin
        int phase;
        int n;
        int pct;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients first, then half-scale ones for rounding ties.
        run_directed();
        drain();
        load_angles(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        run_directed();
        drain();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            pct = 15;
            case (phase)
                0: load_angles(16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
                1: load_angles(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
                2: load_angles(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
                3: begin
                    // Raw 16-bit extremes drive both rotations into saturation.
                    load_angles(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
                    pct = 50;
                end
                4: load_angles(16'sd0, vrp_pkg::COEF_ONE, 16'sd0, vrp_pkg::COEF_ONE);
                default: load_angles(gen_coef(), gen_coef(), gen_coef(), gen_coef());
            endcase
            in_idle_on  <= (phase != 2);
            out_idle_on <= (phase != 2);
            if (phase == 6) pressure_req <= 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_vertex(gen_coord(pct), gen_coord(pct), gen_depth_coord(pct));
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0 && book.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/vrp_pkg.sv
design/vrp_recip.sv
design/vertex_rotate_project_core.sv
bench/vertex_rotate_project_core_test.sv
